[sv/fcema_pkg.sv]
// Shared package for the four-channel moving-average alert smoother.
// Holds field widths, threshold reset values, register indexes and alert bit positions.
// No dependencies.
package fcema_pkg;

    // Field widths of the sample channels, timestamp and alert flags
    localparam int TEMP_W     = 15;
    localparam int HUM_W      = 14;
    localparam int GAS_W      = 16;
    localparam int TS_W       = 32;
    localparam int FLAG_W     = 8;

    // Default number of fraction bits in the averages
    localparam int FRAC_BITS_DEFAULT = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEMP_HIGH = 4'd0,
        CFG_TEMP_LOW  = 4'd1,
        CFG_HUM_HIGH  = 4'd2,
        CFG_HUM_LOW   = 4'd3,
        CFG_ECO2_WARN = 4'd4,
        CFG_ECO2_BAD  = 4'd5,
        CFG_TVOC_WARN = 4'd6,
        CFG_TVOC_BAD  = 4'd7
    } cfg_idx_t;

    // Alert bit positions
    localparam int FLAG_TEMP_HIGH = 0;
    localparam int FLAG_TEMP_LOW  = 1;
    localparam int FLAG_HUM_HIGH  = 2;
    localparam int FLAG_HUM_LOW   = 3;
    localparam int FLAG_ECO2_WARN = 4;
    localparam int FLAG_ECO2_BAD  = 5;
    localparam int FLAG_TVOC_WARN = 6;
    localparam int FLAG_TVOC_BAD  = 7;

    // Threshold set, in sample units (no fraction bits)
    typedef struct packed {
        logic signed [TEMP_W-1:0] temp_high;
        logic signed [TEMP_W-1:0] temp_low;
        logic [HUM_W-1:0]         hum_high;
        logic [HUM_W-1:0]         hum_low;
        logic [GAS_W-1:0]         eco2_warn;
        logic [GAS_W-1:0]         eco2_bad;
        logic [GAS_W-1:0]         tvoc_warn;
        logic [GAS_W-1:0]         tvoc_bad;
    } limits_t;

    localparam limits_t LIMITS_RESET = '{
        temp_high: 15'sd3500,
        temp_low:  15'sd500,
        hum_high:  14'd7000,
        hum_low:   14'd2000,
        eco2_warn: 16'd1000,
        eco2_bad:  16'd2000,
        tvoc_warn: 16'd220,
        tvoc_bad:  16'd660
    };

endpackage

[sv/fcema_ema_channel.sv]
// One channel of the moving-average update: seed or floor((x*2^F + 4*avg)/5).
// Signed channels are worked in offset binary so the floor divide stays unsigned.
// Depends on fcema_pkg.
module fcema_ema_channel import fcema_pkg::*; #(
    parameter int SAMPLE_W  = GAS_W,
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT,
    parameter bit IS_SIGNED = 1'b0,
    localparam int AVG_W    = SAMPLE_W + FRAC_BITS
) (
    input  logic [SAMPLE_W-1:0] sample,
    input  logic [AVG_W-1:0]    avg_cur,
    input  logic                seeded,
    output logic [AVG_W-1:0]    avg_new
);

    // Numerator is below 5 * 2^AVG_W
    localparam int NUM_W = AVG_W + 3;
    localparam int SHIFT = NUM_W + 2;
    // Reciprocal ceil(2^SHIFT / 5); exact floor quotient for any NUM_W-bit numerator
    localparam logic [63:0]      RECIP_FULL = ((64'd1 << SHIFT) + 64'd4) / 64'd5;
    localparam logic [NUM_W-1:0] RECIP      = RECIP_FULL[NUM_W-1:0];

    localparam logic [SAMPLE_W-1:0] S_FLIP = {IS_SIGNED, {(SAMPLE_W-1){1'b0}}};
    localparam logic [AVG_W-1:0]    A_FLIP = {IS_SIGNED, {(AVG_W-1){1'b0}}};

    logic [SAMPLE_W-1:0]  sample_ob;
    logic [AVG_W-1:0]     avg_ob;
    logic [NUM_W-1:0]     numer;
    logic [2*NUM_W-1:0]   prod;
    logic [AVG_W-1:0]     quot_ob;

    // Move to offset binary, weight and sum
    assign sample_ob = sample ^ S_FLIP;
    assign avg_ob    = avg_cur ^ A_FLIP;
    assign numer     = {3'b000, sample_ob, {FRAC_BITS{1'b0}}} + {1'b0, avg_ob, 2'b00};

    // Divide by five through the constant reciprocal
    assign prod      = {{NUM_W{1'b0}}, numer} * {{NUM_W{1'b0}}, RECIP};
    assign quot_ob   = prod[SHIFT +: AVG_W];

    // Seed with the scaled sample on the first request, otherwise take the update
    assign avg_new   = seeded ? (quot_ob ^ A_FLIP) : {sample, {FRAC_BITS{1'b0}}};

endmodule

[sv/fcema_alert_check.sv]
// Threshold compares of the four averages against the scaled limits.
// Produces the eight alert bits. Depends on fcema_pkg.
module fcema_alert_check import fcema_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT,
    localparam int TAVG_W   = TEMP_W + FRAC_BITS,
    localparam int HAVG_W   = HUM_W + FRAC_BITS,
    localparam int GAVG_W   = GAS_W + FRAC_BITS
) (
    input  logic signed [TAVG_W-1:0] temp_avg,
    input  logic [HAVG_W-1:0]        hum_avg,
    input  logic [GAVG_W-1:0]        eco2_avg,
    input  logic [GAVG_W-1:0]        tvoc_avg,
    input  limits_t                  limits,
    output logic [FLAG_W-1:0]        alert_flags
);

    localparam logic [FRAC_BITS-1:0] FRAC_ZERO = '0;

    // Compare each average with its limit shifted up by the fraction bits
    always_comb begin
        alert_flags = '0;
        alert_flags[FLAG_TEMP_HIGH] = temp_avg > $signed({limits.temp_high, FRAC_ZERO});
        alert_flags[FLAG_TEMP_LOW]  = temp_avg < $signed({limits.temp_low, FRAC_ZERO});
        alert_flags[FLAG_HUM_HIGH]  = hum_avg  > {limits.hum_high, FRAC_ZERO};
        alert_flags[FLAG_HUM_LOW]   = hum_avg  < {limits.hum_low, FRAC_ZERO};
        alert_flags[FLAG_ECO2_WARN] = eco2_avg > {limits.eco2_warn, FRAC_ZERO};
        alert_flags[FLAG_ECO2_BAD]  = eco2_avg > {limits.eco2_bad, FRAC_ZERO};
        alert_flags[FLAG_TVOC_WARN] = tvoc_avg > {limits.tvoc_warn, FRAC_ZERO};
        alert_flags[FLAG_TVOC_BAD]  = tvoc_avg > {limits.tvoc_bad, FRAC_ZERO};
    end

endmodule

[sv/four_channel_ema_alert_smoother_core.sv]
// Four-channel moving-average smoother (alpha 1/5) with threshold alerts.
// A request passes through the input register, then the result register, before its result
// can be taken; a stall on the result side can hold it in the input register.
// Throughput: one request per cycle while the result side is not stalled; the average registers
// close a loop through the divide-by-five reciprocal multiply of each channel.
// Reset (aresetn low, synchronous): pipeline empty, averages zero and unseeded, limits at defaults.
module four_channel_ema_alert_smoother_core import fcema_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT,
    localparam int TAVG_W   = TEMP_W + FRAC_BITS,
    localparam int HAVG_W   = HUM_W + FRAC_BITS,
    localparam int GAVG_W   = GAS_W + FRAC_BITS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // configuration writes
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    // sample requests
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [TEMP_W-1:0] s_temperature,
    input  logic [HUM_W-1:0]         s_humidity,
    input  logic [GAS_W-1:0]         s_eco2,
    input  logic [GAS_W-1:0]         s_tvoc,
    input  logic [TS_W-1:0]          s_timestamp,
    // results
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [TAVG_W-1:0] m_temp_smoothed,
    output logic [HAVG_W-1:0]        m_humidity_smoothed,
    output logic [GAVG_W-1:0]        m_eco2_smoothed,
    output logic [GAVG_W-1:0]        m_tvoc_smoothed,
    output logic [TS_W-1:0]          m_sample_time,
    output logic [FLAG_W-1:0]        m_alert_flags
);

    logic                     in_valid_reg;
    logic signed [TEMP_W-1:0] in_temp_reg;
    logic [HUM_W-1:0]         in_hum_reg;
    logic [GAS_W-1:0]         in_eco2_reg;
    logic [GAS_W-1:0]         in_tvoc_reg;
    logic [TS_W-1:0]          in_time_reg;

    logic                     seeded_reg;
    logic [TAVG_W-1:0]        temp_avg_reg;
    logic [HAVG_W-1:0]        hum_avg_reg;
    logic [GAVG_W-1:0]        eco2_avg_reg;
    logic [GAVG_W-1:0]        tvoc_avg_reg;
    logic [TAVG_W-1:0]        temp_avg_next;
    logic [HAVG_W-1:0]        hum_avg_next;
    logic [GAVG_W-1:0]        eco2_avg_next;
    logic [GAVG_W-1:0]        tvoc_avg_next;

    logic                     m_valid_reg;
    logic [TS_W-1:0]          time_out_reg;
    logic [FLAG_W-1:0]        flags_reg;
    logic [FLAG_W-1:0]        flags_next;

    limits_t                  limits_reg;

    logic                     advance;
    logic                     load_in;
    logic                     update;

    // Handshake: result register frees when empty or taken, input register follows
    assign advance = !m_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;
    assign load_in = s_valid && s_ready;
    assign update  = advance && in_valid_reg;

    // Per-channel average update
    fcema_ema_channel #(.SAMPLE_W(TEMP_W), .FRAC_BITS(FRAC_BITS), .IS_SIGNED(1'b1)) u_temp (
        .sample  (in_temp_reg),
        .avg_cur (temp_avg_reg),
        .seeded  (seeded_reg),
        .avg_new (temp_avg_next)
    );

    fcema_ema_channel #(.SAMPLE_W(HUM_W), .FRAC_BITS(FRAC_BITS), .IS_SIGNED(1'b0)) u_hum (
        .sample  (in_hum_reg),
        .avg_cur (hum_avg_reg),
        .seeded  (seeded_reg),
        .avg_new (hum_avg_next)
    );

    fcema_ema_channel #(.SAMPLE_W(GAS_W), .FRAC_BITS(FRAC_BITS), .IS_SIGNED(1'b0)) u_eco2 (
        .sample  (in_eco2_reg),
        .avg_cur (eco2_avg_reg),
        .seeded  (seeded_reg),
        .avg_new (eco2_avg_next)
    );

    fcema_ema_channel #(.SAMPLE_W(GAS_W), .FRAC_BITS(FRAC_BITS), .IS_SIGNED(1'b0)) u_tvoc (
        .sample  (in_tvoc_reg),
        .avg_cur (tvoc_avg_reg),
        .seeded  (seeded_reg),
        .avg_new (tvoc_avg_next)
    );

    // Alerts from the new averages
    fcema_alert_check #(.FRAC_BITS(FRAC_BITS)) u_alert (
        .temp_avg    ($signed(temp_avg_next)),
        .hum_avg     (hum_avg_next),
        .eco2_avg    (eco2_avg_next),
        .tvoc_avg    (tvoc_avg_next),
        .limits      (limits_reg),
        .alert_flags (flags_next)
    );

    // Control state, averages and limits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            seeded_reg   <= 1'b0;
            temp_avg_reg <= '0;
            hum_avg_reg  <= '0;
            eco2_avg_reg <= '0;
            tvoc_avg_reg <= '0;
            limits_reg   <= LIMITS_RESET;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                m_valid_reg <= in_valid_reg;
            end
            if (update) begin
                seeded_reg   <= 1'b1;
                temp_avg_reg <= temp_avg_next;
                hum_avg_reg  <= hum_avg_next;
                eco2_avg_reg <= eco2_avg_next;
                tvoc_avg_reg <= tvoc_avg_next;
            end
            // Register writes; unknown indexes drop
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_TEMP_HIGH: limits_reg.temp_high <= $signed(cfg_data[TEMP_W-1:0]);
                    CFG_TEMP_LOW:  limits_reg.temp_low  <= $signed(cfg_data[TEMP_W-1:0]);
                    CFG_HUM_HIGH:  limits_reg.hum_high  <= cfg_data[HUM_W-1:0];
                    CFG_HUM_LOW:   limits_reg.hum_low   <= cfg_data[HUM_W-1:0];
                    CFG_ECO2_WARN: limits_reg.eco2_warn <= cfg_data[GAS_W-1:0];
                    CFG_ECO2_BAD:  limits_reg.eco2_bad  <= cfg_data[GAS_W-1:0];
                    CFG_TVOC_WARN: limits_reg.tvoc_warn <= cfg_data[GAS_W-1:0];
                    CFG_TVOC_BAD:  limits_reg.tvoc_bad  <= cfg_data[GAS_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Payload: capture the request, then the result side fields
    always_ff @(posedge aclk) begin
        if (load_in) begin
            in_temp_reg <= s_temperature;
            in_hum_reg  <= s_humidity;
            in_eco2_reg <= s_eco2;
            in_tvoc_reg <= s_tvoc;
            in_time_reg <= s_timestamp;
        end
        if (update) begin
            time_out_reg <= in_time_reg;
            flags_reg    <= flags_next;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_temp_smoothed     = $signed(temp_avg_reg);
    assign m_humidity_smoothed = hum_avg_reg;
    assign m_eco2_smoothed     = eco2_avg_reg;
    assign m_tvoc_smoothed     = tvoc_avg_reg;
    assign m_sample_time       = time_out_reg;
    assign m_alert_flags       = flags_reg;

    // A request that moves into the result register marks the averages seeded
    a_seed_after_update: assert property (@(posedge aclk) disable iff (!aresetn)
        update |=> seeded_reg)
        else $error("averages not marked seeded after a request");

    // Once seeded, only reset clears the mark
    a_seed_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        seeded_reg |=> seeded_reg)
        else $error("seeded mark dropped without reset");

    // Averages hold unless a request moves into the result register
    a_avg_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !update |=> $stable(temp_avg_reg) && $stable(hum_avg_reg)
                    && $stable(eco2_avg_reg) && $stable(tvoc_avg_reg))
        else $error("average changed without a request");

    // A held request in the input register is not lost while the result side stalls
    a_input_held: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_time_reg))
        else $error("stalled request lost from the input register");

    // A result only appears from a request held in the input register
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(in_valid_reg))
        else $error("result produced without a request");

endmodule

[tb/tb_top.sv]
// Self-checking bench for the four-channel moving-average alert smoother.
// Predicts the four averages, the passed-through timestamp and the alert bits for every
// request; depends on fcema_pkg and four_channel_ema_alert_smoother_core.
module tb_top import fcema_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC       = FRAC_BITS_DEFAULT;
    localparam int TAVG_W     = TEMP_W + FRAC;
    localparam int HAVG_W     = HUM_W + FRAC;
    localparam int GAVG_W     = GAS_W + FRAC;
    localparam longint SCALE  = longint'(1) << FRAC;
    localparam int NUM_LIMITS = CFG_TVOC_BAD + 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = CFG_IDX_W'(CFG_TVOC_BAD + 1);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = '1;
    localparam int DRAIN_CYCLES = 4;
    localparam int TAIL_CYCLES  = 8;
    localparam int DIR_ROWS     = 21;
    localparam int PHASE_ITEMS  = 242;
    localparam int MAX_REPORTS  = 10;

    typedef enum int {CH_TEMP, CH_HUM, CH_ECO2, CH_TVOC, CH_COUNT} channel_t;
    typedef enum int {LIM_DEFAULT, LIM_RANGE_LOW, LIM_RANGE_HIGH, LIM_BIT_EXTREMES,
                      LIM_RANDOM} limit_set_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp;
        logic [HUM_W-1:0]         hum;
        logic [GAS_W-1:0]         eco2;
        logic [GAS_W-1:0]         tvoc;
        logic [TS_W-1:0]          stamp;
    } reading_t;

    typedef struct packed {
        logic [TAVG_W-1:0] temp;
        logic [HAVG_W-1:0] hum;
        logic [GAVG_W-1:0] eco2;
        logic [GAVG_W-1:0] tvoc;
        logic [TS_W-1:0]   stamp;
        logic [FLAG_W-1:0] flags;
    } smoothed_t;

    typedef struct packed {
        reading_t  smp;
        logic      known;
        smoothed_t want;
    } dir_row_t;

    localparam smoothed_t UNTYPED = '0;

    logic aclk;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [TEMP_W-1:0] s_temperature = '0;
    logic [HUM_W-1:0] s_humidity = '0;
    logic [GAS_W-1:0] s_eco2 = '0;
    logic [GAS_W-1:0] s_tvoc = '0;
    logic [TS_W-1:0] s_timestamp = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [TAVG_W-1:0] m_temp_smoothed;
    logic [HAVG_W-1:0] m_humidity_smoothed;
    logic [GAVG_W-1:0] m_eco2_smoothed;
    logic [GAVG_W-1:0] m_tvoc_smoothed;
    logic [TS_W-1:0] m_sample_time;
    logic [FLAG_W-1:0] m_alert_flags;

    // Predictor state: running averages, seed flag and thresholds
    longint    avg_model [CH_COUNT];
    bit        seeded_model;
    longint    limit_val [NUM_LIMITS];
    smoothed_t smoothed_due [$];
    dir_row_t  directed_rows [DIR_ROWS];
    smoothed_t seen_result;
    smoothed_t oldest_result;
    int        send_idle = 0;
    int        recv_stall = 0;
    int        fail_count = 0;

    four_channel_ema_alert_smoother_core #(.FRAC_BITS(FRAC)) dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_temperature       (s_temperature),
        .s_humidity          (s_humidity),
        .s_eco2              (s_eco2),
        .s_tvoc              (s_tvoc),
        .s_timestamp         (s_timestamp),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_temp_smoothed     (m_temp_smoothed),
        .m_humidity_smoothed (m_humidity_smoothed),
        .m_eco2_smoothed     (m_eco2_smoothed),
        .m_tvoc_smoothed     (m_tvoc_smoothed),
        .m_sample_time       (m_sample_time),
        .m_alert_flags       (m_alert_flags)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #4000000;
        $display("FAILED: results differ");
        $finish;
    end

    // Stall the result channel at the current rate
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall);
    end

    function automatic reading_t reading(int t, int h, int e, int v, logic [TS_W-1:0] ts);
        reading_t r;
        r.temp  = t[TEMP_W-1:0];
        r.hum   = h[HUM_W-1:0];
        r.eco2  = e[GAS_W-1:0];
        r.tvoc  = v[GAS_W-1:0];
        r.stamp = ts;
        return r;
    endfunction

    // Track a threshold write; spare indexes leave everything as it was
    function automatic void note_limit_write(logic [CFG_IDX_W-1:0] idx,
                                             logic [CFG_DATA_W-1:0] data);
        case (idx) inside
            CFG_TEMP_HIGH, CFG_TEMP_LOW: limit_val[idx] = longint'(signed'(data[TEMP_W-1:0]));
            CFG_HUM_HIGH, CFG_HUM_LOW:   limit_val[idx] = longint'(data[HUM_W-1:0]);
            CFG_ECO2_WARN, CFG_ECO2_BAD,
            CFG_TVOC_WARN, CFG_TVOC_BAD: limit_val[idx] = longint'(data[GAS_W-1:0]);
            default: ;
        endcase
    endfunction

    // Seed or update the four averages, then derive the alert bits
    function automatic smoothed_t advance_averages(reading_t smp);
        longint            x [CH_COUNT];
        longint            n;
        longint            q;
        logic [FLAG_W-1:0] f;
        smoothed_t         r;
        x[CH_TEMP] = longint'(signed'(smp.temp));
        x[CH_HUM]  = longint'(smp.hum);
        x[CH_ECO2] = longint'(smp.eco2);
        x[CH_TVOC] = longint'(smp.tvoc);
        for (int c = 0; c < CH_COUNT; c++) begin
            if (!seeded_model) begin
                avg_model[c] = x[c] * SCALE;
            end else begin
                // floor division: round negative sums towards minus infinity
                n = x[c] * SCALE + 4 * avg_model[c];
                q = n / 5;
                if (n % 5 != 0 && n < 0) q = q - 1;
                avg_model[c] = q;
            end
        end
        seeded_model = 1'b1;
        f = '0;
        f[FLAG_TEMP_HIGH] = avg_model[CH_TEMP] > limit_val[CFG_TEMP_HIGH] * SCALE;
        f[FLAG_TEMP_LOW]  = avg_model[CH_TEMP] < limit_val[CFG_TEMP_LOW] * SCALE;
        f[FLAG_HUM_HIGH]  = avg_model[CH_HUM] > limit_val[CFG_HUM_HIGH] * SCALE;
        f[FLAG_HUM_LOW]   = avg_model[CH_HUM] < limit_val[CFG_HUM_LOW] * SCALE;
        f[FLAG_ECO2_WARN] = avg_model[CH_ECO2] > limit_val[CFG_ECO2_WARN] * SCALE;
        f[FLAG_ECO2_BAD]  = avg_model[CH_ECO2] > limit_val[CFG_ECO2_BAD] * SCALE;
        f[FLAG_TVOC_WARN] = avg_model[CH_TVOC] > limit_val[CFG_TVOC_WARN] * SCALE;
        f[FLAG_TVOC_BAD]  = avg_model[CH_TVOC] > limit_val[CFG_TVOC_BAD] * SCALE;
        r.temp  = avg_model[CH_TEMP][TAVG_W-1:0];
        r.hum   = avg_model[CH_HUM][HAVG_W-1:0];
        r.eco2  = avg_model[CH_ECO2][GAVG_W-1:0];
        r.tvoc  = avg_model[CH_TVOC][GAVG_W-1:0];
        r.stamp = smp.stamp;
        r.flags = f;
        return r;
    endfunction

    // Mix raw bit patterns, in-range readings and readings close to the thresholds
    function automatic reading_t random_reading();
        int mode;
        int t;
        int h;
        int e;
        int v;
        mode = $urandom_range(0, 9);
        if (mode < 2) begin
            t = $urandom;
            h = $urandom;
            e = $urandom;
            v = $urandom;
        end else if (mode < 6) begin
            t = int'($urandom_range(0, 16500)) - 4000;
            h = $urandom_range(0, 10000);
            e = $urandom_range(0, 65535);
            v = $urandom_range(0, 65535);
        end else begin
            t = int'(limit_val[$urandom_range(0, 1) ? CFG_TEMP_HIGH : CFG_TEMP_LOW]);
            h = int'(limit_val[$urandom_range(0, 1) ? CFG_HUM_HIGH : CFG_HUM_LOW]);
            e = int'(limit_val[$urandom_range(0, 1) ? CFG_ECO2_WARN : CFG_ECO2_BAD]);
            v = int'(limit_val[$urandom_range(0, 1) ? CFG_TVOC_WARN : CFG_TVOC_BAD]);
            t = t + int'($urandom_range(0, 64)) - 32;
            h = h + int'($urandom_range(0, 64)) - 32;
            e = e + int'($urandom_range(0, 64)) - 32;
            v = v + int'($urandom_range(0, 64)) - 32;
        end
        return reading(t, h, e, v, $urandom);
    endfunction

    // Offer one request, idling first at the current rate; optionally hold until drained
    task automatic drive_reading(reading_t smp, logic known, smoothed_t want, bit hold);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle) gap++;
        if (gap > 0 || (hold && smoothed_due.size() != 0)) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
            while (hold && smoothed_due.size() != 0) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_temperature <= smp.temp;
        s_humidity    <= smp.hum;
        s_eco2        <= smp.eco2;
        s_tvoc        <= smp.tvoc;
        s_timestamp   <= smp.stamp;
        do @(posedge aclk); while (!s_ready);
        want = known ? want : advance_averages(smp);
        if (known) void'(advance_averages(smp));
        smoothed_due.push_back(want);
    endtask

    // Drop valid, wait for every outstanding result, then let the pipeline drain
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (smoothed_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Write all eight thresholds, then one spare index that must be ignored
    task automatic load_limits(limit_set_t set);
        logic [CFG_DATA_W-1:0] lim_data [NUM_LIMITS];
        logic [CFG_IDX_W-1:0]  spare;
        logic [CFG_DATA_W-1:0] spare_data;
        wait_idle();
        case (set)
            LIM_DEFAULT: begin
                lim_data[CFG_TEMP_HIGH] = CFG_DATA_W'(signed'(LIMITS_RESET.temp_high));
                lim_data[CFG_TEMP_LOW]  = CFG_DATA_W'(signed'(LIMITS_RESET.temp_low));
                lim_data[CFG_HUM_HIGH]  = CFG_DATA_W'(LIMITS_RESET.hum_high);
                lim_data[CFG_HUM_LOW]   = CFG_DATA_W'(LIMITS_RESET.hum_low);
                lim_data[CFG_ECO2_WARN] = LIMITS_RESET.eco2_warn;
                lim_data[CFG_ECO2_BAD]  = LIMITS_RESET.eco2_bad;
                lim_data[CFG_TVOC_WARN] = LIMITS_RESET.tvoc_warn;
                lim_data[CFG_TVOC_BAD]  = LIMITS_RESET.tvoc_bad;
            end
            LIM_RANGE_LOW: begin
                lim_data[CFG_TEMP_HIGH] = CFG_DATA_W'(-4000);
                lim_data[CFG_TEMP_LOW]  = CFG_DATA_W'(-4000);
                lim_data[CFG_HUM_HIGH]  = '0;
                lim_data[CFG_HUM_LOW]   = '0;
                lim_data[CFG_ECO2_WARN] = '0;
                lim_data[CFG_ECO2_BAD]  = '0;
                lim_data[CFG_TVOC_WARN] = '0;
                lim_data[CFG_TVOC_BAD]  = '0;
            end
            LIM_RANGE_HIGH: begin
                lim_data[CFG_TEMP_HIGH] = 16'd12500;
                lim_data[CFG_TEMP_LOW]  = 16'd12500;
                lim_data[CFG_HUM_HIGH]  = 16'd10000;
                lim_data[CFG_HUM_LOW]   = 16'd10000;
                lim_data[CFG_ECO2_WARN] = 16'hFFFF;
                lim_data[CFG_ECO2_BAD]  = 16'hFFFF;
                lim_data[CFG_TVOC_WARN] = 16'hFFFF;
                lim_data[CFG_TVOC_BAD]  = 16'hFFFF;
            end
            LIM_BIT_EXTREMES: begin
                // upper data bits set beyond the register width on some; eCO2 warn above bad
                lim_data[CFG_TEMP_HIGH] = 16'hC000;
                lim_data[CFG_TEMP_LOW]  = 16'h3FFF;
                lim_data[CFG_HUM_HIGH]  = 16'hFFFF;
                lim_data[CFG_HUM_LOW]   = 16'hC000;
                lim_data[CFG_ECO2_WARN] = 16'hFFFF;
                lim_data[CFG_ECO2_BAD]  = 16'h0000;
                lim_data[CFG_TVOC_WARN] = 16'h0000;
                lim_data[CFG_TVOC_BAD]  = 16'hFFFF;
            end
            default: begin
                for (int i = CFG_TEMP_HIGH; i <= CFG_TVOC_BAD; i++) begin
                    lim_data[i] = CFG_DATA_W'($urandom_range(0, 16'hFFFF));
                end
            end
        endcase
        for (int i = CFG_TEMP_HIGH; i <= CFG_TVOC_BAD; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= lim_data[i];
            @(posedge aclk);
            note_limit_write(CFG_IDX_W'(i), lim_data[i]);
        end
        spare      = CFG_IDX_W'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST));
        spare_data = CFG_DATA_W'($urandom_range(0, 16'hFFFF));
        cfg_index <= spare;
        cfg_data  <= spare_data;
        @(posedge aclk);
        note_limit_write(spare, spare_data);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Compare each result with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            seen_result = '{m_temp_smoothed, m_humidity_smoothed, m_eco2_smoothed,
                            m_tvoc_smoothed, m_sample_time, m_alert_flags};
            if (smoothed_due.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected result: t=%h h=%h e=%h v=%h ts=%h f=%h",
                             seen_result.temp, seen_result.hum, seen_result.eco2,
                             seen_result.tvoc, seen_result.stamp, seen_result.flags);
            end else begin
                oldest_result = smoothed_due.pop_front();
                if (seen_result.temp !== oldest_result.temp
                        || seen_result.hum !== oldest_result.hum
                        || seen_result.eco2 !== oldest_result.eco2
                        || seen_result.tvoc !== oldest_result.tvoc
                        || seen_result.stamp !== oldest_result.stamp
                        || seen_result.flags !== oldest_result.flags) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display({"mismatch: want t=%h h=%h e=%h v=%h ts=%h f=%h",
                                  " got t=%h h=%h e=%h v=%h ts=%h f=%h"},
                                 oldest_result.temp, oldest_result.hum, oldest_result.eco2,
                                 oldest_result.tvoc, oldest_result.stamp, oldest_result.flags,
                                 seen_result.temp, seen_result.hum, seen_result.eco2,
                                 seen_result.tvoc, seen_result.stamp, seen_result.flags);
                end
            end
        end
    end

    // Main sequence: reset, directed table, then randomised phases
    initial begin
        seeded_model = 1'b0;
        for (int c = 0; c < CH_COUNT; c++) avg_model[c] = 0;
        limit_val[CFG_TEMP_HIGH] = longint'(signed'(LIMITS_RESET.temp_high));
        limit_val[CFG_TEMP_LOW]  = longint'(signed'(LIMITS_RESET.temp_low));
        limit_val[CFG_HUM_HIGH]  = longint'(LIMITS_RESET.hum_high);
        limit_val[CFG_HUM_LOW]   = longint'(LIMITS_RESET.hum_low);
        limit_val[CFG_ECO2_WARN] = longint'(LIMITS_RESET.eco2_warn);
        limit_val[CFG_ECO2_BAD]  = longint'(LIMITS_RESET.eco2_bad);
        limit_val[CFG_TVOC_WARN] = longint'(LIMITS_RESET.tvoc_warn);
        limit_val[CFG_TVOC_BAD]  = longint'(LIMITS_RESET.tvoc_bad);

        // first request seeds, a repeat keeps the average exact; then extremes,
        // negative floor cases, range ends and readings right at the thresholds
        directed_rows = '{
            '{reading(2000, 5000, 500, 100, 32'h0000_0000), 1'b1,
              '{23'd512000, 22'd1280000, 24'd128000, 24'd25600, 32'h0000_0000, 8'h00}},
            '{reading(2000, 5000, 500, 100, 32'hFFFF_FFFF), 1'b1,
              '{23'd512000, 22'd1280000, 24'd128000, 24'd25600, 32'hFFFF_FFFF, 8'h00}},
            '{reading(16383, 16383, 65535, 65535, 32'h0000_0001), 1'b0, UNTYPED},
            '{reading(16383, 16383, 65535, 65535, 32'h8000_0000), 1'b0, UNTYPED},
            '{reading(16383, 16383, 65535, 65535, 32'h7FFF_FFFF), 1'b0, UNTYPED},
            '{reading(-16384, 0, 0, 0, 32'hAAAA_5555), 1'b0, UNTYPED},
            '{reading(-16384, 0, 0, 0, 32'h5555_AAAA), 1'b0, UNTYPED},
            '{reading(-16384, 0, 0, 0, 32'h0000_FFFF), 1'b0, UNTYPED},
            '{reading(-16384, 0, 0, 0, 32'hFFFF_0000), 1'b0, UNTYPED},
            '{reading(-1, 1, 1, 1, 32'h0000_0002), 1'b0, UNTYPED},
            '{reading(-3, 0, 2, 3, 32'h0000_0003), 1'b0, UNTYPED},
            '{reading(-4000, 0, 0, 0, 32'h0000_0004), 1'b0, UNTYPED},
            '{reading(-4000, 0, 0, 0, 32'h0000_0005), 1'b0, UNTYPED},
            '{reading(12500, 10000, 65535, 65535, 32'h0000_0006), 1'b0, UNTYPED},
            '{reading(12500, 10000, 65535, 65535, 32'h0000_0007), 1'b0, UNTYPED},
            '{reading(3500, 7000, 1000, 220, 32'h0000_0008), 1'b0, UNTYPED},
            '{reading(3500, 7000, 1000, 220, 32'h0000_0009), 1'b0, UNTYPED},
            '{reading(3500, 7000, 1000, 220, 32'h0000_000A), 1'b0, UNTYPED},
            '{reading(500, 2000, 2000, 660, 32'h0000_000B), 1'b0, UNTYPED},
            '{reading(500, 2000, 2000, 660, 32'h0000_000C), 1'b0, UNTYPED},
            '{reading(500, 2000, 2000, 660, 32'h0000_000D), 1'b0, UNTYPED}
        };

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            drive_reading(directed_rows[i].smp, directed_rows[i].known,
                          directed_rows[i].want, 1'b0);
        end

        // phases: idle rate, stall rate and threshold set change together
        for (int p = 0; p < 6; p++) begin
            case (p % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 80; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 80; end
                default: begin send_idle = 18; recv_stall = 18; end
            endcase
            case (p)
                0: load_limits(LIM_RANGE_HIGH);
                1: load_limits(LIM_RANGE_LOW);
                2: load_limits(LIM_BIT_EXTREMES);
                3: load_limits(LIM_RANDOM);
                4: load_limits(LIM_RANDOM);
                default: load_limits(LIM_DEFAULT);
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                drive_reading(random_reading(), 1'b0, UNTYPED, p == 3 && n % 60 == 30);
            end
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/fcema_pkg.sv
sv/fcema_ema_channel.sv
sv/fcema_alert_check.sv
sv/four_channel_ema_alert_smoother_core.sv
tb/tb_top.sv
